/* design/kfss_pkg.sv */
package kfss_pkg;

    // one complex Q-format value
    typedef struct packed {
        logic signed [31:0] im;
        logic signed [31:0] re;
    } cval_t;

    // control of the complex multiply-accumulate unit
    typedef struct packed {
        logic acc_clr;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

    // item function codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // array selects of a load
    localparam logic [3:0] SEL_V    = 4'd0;
    localparam logic [3:0] SEL_K    = 4'd1;
    localparam logic [3:0] SEL_FINV = 4'd2;
    localparam logic [3:0] SEL_Z    = 4'd3;
    localparam logic [3:0] SEL_T    = 4'd4;
    localparam logic [3:0] SEL_R    = 4'd5;
    localparam logic [3:0] SEL_Q    = 4'd6;
    localparam logic [3:0] SEL_PM   = 4'd7;
    localparam logic [3:0] SEL_PC   = 4'd8;

    // configuration register indexes
    localparam logic [2:0] CFG_NUM_TIMES = 3'd0;
    localparam logic [2:0] CFG_OBS_DIM   = 3'd1;
    localparam logic [2:0] CFG_STATE_DIM = 3'd2;
    localparam logic [2:0] CFG_NOISE_DIM = 3'd3;
    localparam logic [2:0] CFG_VARYING   = 3'd4;

    // result kinds
    localparam logic KIND_DONE  = 1'b0;
    localparam logic KIND_STATE = 1'b1;

    // saturate a wide sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'(x);
        end
        return r;
    endfunction

    // saturating complex add or subtract
    function automatic cval_t cadd(input cval_t a, input cval_t b, input logic sub);
        cval_t r;
        logic signed [63:0] sre;
        logic signed [63:0] sim;
        sre = sub ? (64'(a.re) - 64'(b.re)) : (64'(a.re) + 64'(b.re));
        sim = sub ? (64'(a.im) - 64'(b.im)) : (64'(a.im) + 64'(b.im));
        r.re = sat32(sre);
        r.im = sat32(sim);
        return r;
    endfunction

endpackage

/* design/kfss_cmac.sv */
module kfss_cmac
    import kfss_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      aclk,
    input  mac_ctrl_t ctrl,
    input  cval_t     x,
    input  cval_t     y,
    output cval_t     res
);

    logic signed [63:0] p_rr_reg;
    logic signed [63:0] p_ii_reg;
    logic signed [63:0] p_ri_reg;
    logic signed [63:0] p_ir_reg;
    logic signed [63:0] acc_re_reg;
    logic signed [63:0] acc_im_reg;
    logic signed [63:0] acc_re_next;
    logic signed [63:0] acc_im_next;

    // product stage
    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            p_rr_reg <= 64'(x.re) * 64'(y.re);
            p_ii_reg <= 64'(x.im) * 64'(y.im);
            p_ri_reg <= 64'(x.re) * 64'(y.im);
            p_ir_reg <= 64'(x.im) * 64'(y.re);
        end
    end

    // floor-shifted products into the accumulator
    always_comb begin
        acc_re_next = acc_re_reg + (p_rr_reg >>> FRAC_BITS) - (p_ii_reg >>> FRAC_BITS);
        acc_im_next = acc_im_reg + (p_ri_reg >>> FRAC_BITS) + (p_ir_reg >>> FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.acc_clr) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (ctrl.acc_en) begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    assign res.re = sat32(acc_re_reg);
    assign res.im = sat32(acc_im_reg);

endmodule

/* design/kalman_fast_state_smoother.sv */
// channel  direction  tdata (low bit up)                          tuser
// s_       in         time_index, row, col, value_re, value_im    func, array_sel
// m_       out        out_time, out_state, state_re, state_im     kind
//
// a load is written as it is taken; a read waits for its result to be taken.
// a start first clears the 2*MAX_TIMES*MAX_STATE+MAX_STATE entries of r and the smoothed
// states, one entry a cycle, then runs the recursions on one complex multiply-accumulate
// unit, with an address, a multiply and an accumulate step per product term and an end
// step per result element.
// after reset the same clearing pass runs before the first item is taken.
// no item is taken while a result waits on the m_ side.
module kalman_fast_state_smoother
    import kfss_pkg::*;
#(
    parameter int MAX_TIMES = 64,
    parameter int MAX_OBS   = 4,
    parameter int MAX_STATE = 8,
    parameter int MAX_NOISE = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // time_index[5:0], row[8:6], col[11:9], value_re[43:12], value_im[75:44]
    input  logic [79:0] s_tdata,
    // func[1:0], array_sel[5:2]
    input  logic [5:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_time[5:0], out_state[8:6], state_re[40:9], state_im[72:41]
    output logic [79:0] m_tdata,
    // kind[0]
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_wdata
);

    localparam int T = MAX_TIMES;
    localparam int O = MAX_OBS;
    localparam int S = MAX_STATE;
    localparam int N = MAX_NOISE;
    localparam int MAX_DIM = (S > O ? (S > N ? S : N) : (O > N ? O : N));

    // load memory layout
    localparam int A_V    = 0;
    localparam int A_K    = A_V + T * O;
    localparam int A_F    = A_K + T * S * O;
    localparam int A_Z    = A_F + T * O * O;
    localparam int A_T    = A_Z + T * O * S;
    localparam int A_R    = A_T + T * S * S;
    localparam int A_Q    = A_R + T * S * N;
    localparam int A_PM   = A_Q + T * N * N;
    localparam int A_PC   = A_PM + S;
    localparam int A_DEPTH = A_PC + S * S;
    localparam int AAW    = $clog2(A_DEPTH);

    // work memory layout
    localparam int B_R    = 0;
    localparam int B_RI   = B_R + T * S;
    localparam int B_AL   = B_RI + S;
    localparam int B_RQR  = B_AL + T * S;
    localparam int B_RQ   = B_RQR + S * S;
    localparam int B_U    = B_RQ + S * N;
    localparam int B_DEPTH = B_U + O;
    localparam int BAW    = $clog2(B_DEPTH);
    localparam int CLR_LEN = B_RQR;
    localparam int CLW    = $clog2(CLR_LEN + 1);

    localparam int TW  = $clog2(T);
    localparam int TCW = $clog2(T + 1);
    localparam int CW  = $clog2(MAX_DIM + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [3:0] PH_U1  = 4'd0;
    localparam logic [3:0] PH_U2  = 4'd1;
    localparam logic [3:0] PH_W1  = 4'd2;
    localparam logic [3:0] PH_W2  = 4'd3;
    localparam logic [3:0] PH_A0  = 4'd4;
    localparam logic [3:0] PH_AM  = 4'd5;
    localparam logic [3:0] PH_RQ  = 4'd6;
    localparam logic [3:0] PH_RQR = 4'd7;
    localparam logic [3:0] PH_F1  = 4'd8;
    localparam logic [3:0] PH_F2  = 4'd9;

    localparam logic [1:0] SUB_ADDR = 2'd0;
    localparam logic [1:0] SUB_MUL  = 2'd1;
    localparam logic [1:0] SUB_ACC  = 2'd2;
    localparam logic [1:0] SUB_END  = 2'd3;

    localparam logic [1:0] Y_A   = 2'd0;
    localparam logic [1:0] Y_B   = 2'd1;
    localparam logic [1:0] Y_ONE = 2'd2;

    // item fields
    logic [1:0]  f_func;
    logic [3:0]  f_sel;
    logic [5:0]  f_time;
    logic [2:0]  f_row;
    logic [2:0]  f_col;
    cval_t       f_val;
    logic        s_acc;

    assign f_func    = s_tuser[1:0];
    assign f_sel     = s_tuser[5:2];
    assign f_time    = s_tdata[5:0];
    assign f_row     = s_tdata[8:6];
    assign f_col     = s_tdata[11:9];
    assign f_val.re  = s_tdata[43:12];
    assign f_val.im  = s_tdata[75:44];

    // configuration registers
    logic [6:0] num_times_reg;
    logic [2:0] obs_dim_reg;
    logic [3:0] state_dim_reg;
    logic [2:0] noise_dim_reg;
    logic [3:0] varying_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_times_reg <= 7'd1;
            obs_dim_reg   <= 3'd1;
            state_dim_reg <= 4'd1;
            noise_dim_reg <= 3'd1;
            varying_reg   <= 4'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NUM_TIMES: num_times_reg <= cfg_wdata;
                CFG_OBS_DIM:   obs_dim_reg   <= cfg_wdata[2:0];
                CFG_STATE_DIM: state_dim_reg <= cfg_wdata[3:0];
                CFG_NOISE_DIM: noise_dim_reg <= cfg_wdata[2:0];
                CFG_VARYING:   varying_reg   <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // control registers
    logic [2:0]     state_reg, state_next;
    logic [3:0]     phase_reg, phase_next;
    logic [1:0]     sub_reg, sub_next;
    logic [TW-1:0]  t_reg, t_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [CLW-1:0] clr_reg, clr_next;
    logic           run_pend_reg, run_pend_next;
    logic [TCW-1:0] n_reg, n_next;
    logic [CW-1:0]  np_reg, np_next;
    logic [CW-1:0]  nm_reg, nm_next;
    logic [CW-1:0]  nr_reg, nr_next;
    cval_t          d0_reg, d0_next;
    logic           rd_ok_reg, rd_ok_next;
    logic [5:0]     rd_time_reg, rd_time_next;
    logic [2:0]     rd_row_reg, rd_row_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_kind_reg, out_kind_next;
    logic [5:0]     out_time_reg, out_time_next;
    logic [2:0]     out_state_reg, out_state_next;
    cval_t          out_val_reg, out_val_next;

    // memories
    cval_t mem_a [A_DEPTH];
    cval_t mem_b [B_DEPTH];
    logic            a_we;
    logic [AAW-1:0]  a_waddr;
    logic [AAW-1:0]  a_raddr0, a_raddr1;
    cval_t           a_rdata0_reg, a_rdata1_reg;
    logic            b_we;
    logic [BAW-1:0]  b_waddr;
    cval_t           b_wdata;
    logic [BAW-1:0]  b_raddr0, b_raddr1;
    cval_t           b_rdata0_reg, b_rdata1_reg;

    always_ff @(posedge aclk) begin
        if (a_we) begin
            mem_a[a_waddr] <= f_val;
        end
        a_rdata0_reg <= mem_a[a_raddr0];
        a_rdata1_reg <= mem_a[a_raddr1];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            mem_b[b_waddr] <= b_wdata;
        end
        b_rdata0_reg <= mem_b[b_raddr0];
        b_rdata1_reg <= mem_b[b_raddr1];
    end

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign s_acc    = s_tvalid && s_tready;

    // load decode
    always_comb begin
        int ti, ri, ci;
        logic ok;
        ti = int'(f_time);
        ri = int'(f_row);
        ci = int'(f_col);
        ok = 1'b0;
        a_waddr = '0;
        case (f_sel)
            SEL_V: begin
                ok = (ti < T) && (ri < O);
                a_waddr = AAW'(A_V + ti * O + ri);
            end
            SEL_K: begin
                ok = (ti < T) && (ri < S) && (ci < O);
                a_waddr = AAW'(A_K + (ti * S + ri) * O + ci);
            end
            SEL_FINV: begin
                ok = (ti < T) && (ri < O) && (ci < O);
                a_waddr = AAW'(A_F + (ti * O + ri) * O + ci);
            end
            SEL_Z: begin
                ok = (ti < T) && (ri < O) && (ci < S);
                a_waddr = AAW'(A_Z + (ti * O + ri) * S + ci);
            end
            SEL_T: begin
                ok = (ti < T) && (ri < S) && (ci < S);
                a_waddr = AAW'(A_T + (ti * S + ri) * S + ci);
            end
            SEL_R: begin
                ok = (ti < T) && (ri < S) && (ci < N);
                a_waddr = AAW'(A_R + (ti * S + ri) * N + ci);
            end
            SEL_Q: begin
                ok = (ti < T) && (ri < N) && (ci < N);
                a_waddr = AAW'(A_Q + (ti * N + ri) * N + ci);
            end
            SEL_PM: begin
                ok = (ri < S);
                a_waddr = AAW'(A_PM + ri);
            end
            SEL_PC: begin
                ok = (ri < S) && (ci < S);
                a_waddr = AAW'(A_PC + ri * S + ci);
            end
            default: ok = 1'b0;
        endcase
        a_we = s_acc && (f_func == FUNC_LOAD) && ok;
    end

    // sequencer operand addresses and sources
    int tz, tt, tr, tq;
    logic x_from_b;
    logic [1:0] y_src;
    logic [CW-1:0] len;
    cval_t mac_x, mac_y, mac_res;
    mac_ctrl_t mac_ctrl;

    always_comb begin
        int t, i, j, k;
        t = int'(t_reg);
        i = int'(i_reg);
        j = int'(j_reg);
        k = int'(k_reg);
        tz = varying_reg[3] ? t : 0;
        tt = varying_reg[0] ? t : 0;
        tr = varying_reg[1] ? t : 0;
        tq = varying_reg[2] ? t : 0;
        a_raddr0 = '0;
        a_raddr1 = '0;
        b_raddr0 = '0;
        b_raddr1 = '0;
        x_from_b = 1'b0;
        y_src    = Y_A;
        len      = nm_reg;
        if (state_reg == ST_IDLE) begin
            b_raddr0 = BAW'(B_AL + int'(f_time) * S + int'(f_row));
        end else begin
            unique case (phase_reg)
                PH_U1: begin
                    a_raddr0 = AAW'(A_F + (t * O + i) * O + k);
                    a_raddr1 = AAW'(A_V + t * O + k);
                    len = np_reg;
                end
                PH_U2: begin
                    a_raddr0 = AAW'(A_K + (t * S + k) * O + i);
                    b_raddr1 = BAW'(B_R + t * S + k);
                    y_src = Y_B;
                end
                PH_W1: begin
                    a_raddr0 = AAW'(A_Z + (tz * O + k) * S + i);
                    b_raddr1 = BAW'(B_U + k);
                    y_src = Y_B;
                    len = np_reg;
                end
                PH_W2: begin
                    a_raddr0 = AAW'(A_T + (tt * S + k) * S + i);
                    b_raddr1 = BAW'(B_R + t * S + k);
                    y_src = Y_B;
                end
                PH_A0: begin
                    a_raddr0 = AAW'(A_PC + i * S + k);
                    b_raddr1 = BAW'(B_RI + k);
                    y_src = Y_B;
                end
                PH_AM: begin
                    a_raddr0 = AAW'(A_PM + i);
                    y_src = Y_ONE;
                    len = CW'(1);
                end
                PH_RQ: begin
                    a_raddr0 = AAW'(A_R + (tr * S + i) * N + k);
                    a_raddr1 = AAW'(A_Q + (tq * N + k) * N + j);
                    len = nr_reg;
                end
                PH_RQR: begin
                    b_raddr0 = BAW'(B_RQ + i * N + k);
                    a_raddr1 = AAW'(A_R + (tr * S + j) * N + k);
                    x_from_b = 1'b1;
                    len = nr_reg;
                end
                PH_F1: begin
                    a_raddr0 = AAW'(A_T + (tt * S + i) * S + k);
                    b_raddr1 = BAW'(B_AL + t * S + k);
                    y_src = Y_B;
                end
                PH_F2: begin
                    b_raddr0 = BAW'(B_RQR + i * S + k);
                    b_raddr1 = BAW'(B_R + t * S + k);
                    x_from_b = 1'b1;
                    y_src = Y_B;
                end
                default: ;
            endcase
        end
    end

    // operand select
    always_comb begin
        mac_x = x_from_b ? b_rdata0_reg : a_rdata0_reg;
        case (y_src)
            Y_B:     mac_y = b_rdata1_reg;
            Y_ONE: begin
                mac_y.re = 32'sd1 <<< FRAC_BITS;
                mac_y.im = '0;
            end
            default: mac_y = a_rdata1_reg;
        endcase
    end

    kfss_cmac #(
        .FRAC_BITS(FRAC_BITS)
    ) u_cmac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .x    (mac_x),
        .y    (mac_y),
        .res  (mac_res)
    );

    // main control
    always_comb begin
        int cn, cp, cm, cr;
        logic i_last, j_last;
        cval_t sum;
        cval_t diff;
        state_next     = state_reg;
        phase_next     = phase_reg;
        sub_next       = sub_reg;
        t_next         = t_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        clr_next       = clr_reg;
        run_pend_next  = run_pend_reg;
        n_next         = n_reg;
        np_next        = np_reg;
        nm_next        = nm_reg;
        nr_next        = nr_reg;
        d0_next        = d0_reg;
        rd_ok_next     = rd_ok_reg;
        rd_time_next   = rd_time_reg;
        rd_row_next    = rd_row_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_time_next  = out_time_reg;
        out_state_next = out_state_reg;
        out_val_next   = out_val_reg;
        mac_ctrl       = '0;
        b_we           = 1'b0;
        b_waddr        = '0;
        b_wdata        = '0;
        sum            = cadd(d0_reg, mac_res, 1'b0);
        diff           = cadd(d0_reg, mac_res, 1'b1);
        i_last         = (i_reg == nm_reg - CW'(1));
        j_last         = 1'b0;

        // clamped dimensions for a start
        cn = (num_times_reg == '0) ? 1 : (int'(num_times_reg) > T ? T : int'(num_times_reg));
        cp = (obs_dim_reg == '0) ? 1 : (int'(obs_dim_reg) > O ? O : int'(obs_dim_reg));
        cm = (state_dim_reg == '0) ? 1 : (int'(state_dim_reg) > S ? S : int'(state_dim_reg));
        cr = (noise_dim_reg == '0) ? 1 : (int'(noise_dim_reg) > N ? N : int'(noise_dim_reg));

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                b_we     = 1'b1;
                b_waddr  = BAW'(clr_reg);
                clr_next = clr_reg + CLW'(1);
                if (clr_reg == CLW'(CLR_LEN - 1)) begin
                    state_next    = run_pend_reg ? ST_RUN : ST_IDLE;
                    run_pend_next = 1'b0;
                    clr_next      = '0;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    case (f_func)
                        FUNC_START: begin
                            n_next        = TCW'(cn);
                            np_next       = CW'(cp);
                            nm_next       = CW'(cm);
                            nr_next       = CW'(cr);
                            t_next        = TW'(cn - 1);
                            i_next        = '0;
                            j_next        = '0;
                            k_next        = '0;
                            phase_next    = PH_U1;
                            sub_next      = SUB_ADDR;
                            run_pend_next = 1'b1;
                            clr_next      = '0;
                            mac_ctrl.acc_clr = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        FUNC_READ: begin
                            rd_ok_next   = (int'(f_time) < T) && (int'(f_row) < S);
                            rd_time_next = f_time;
                            rd_row_next  = f_row;
                            state_next   = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_STATE;
                out_time_next  = rd_time_reg;
                out_state_next = rd_row_reg;
                out_val_next   = rd_ok_reg ? b_rdata0_reg : '0;
                state_next     = ST_IDLE;
            end
            ST_RUN: begin
                unique case (sub_reg)
                    SUB_ADDR: sub_next = SUB_MUL;
                    SUB_MUL: begin
                        mac_ctrl.mul_en = 1'b1;
                        sub_next = SUB_ACC;
                    end
                    SUB_ACC: begin
                        mac_ctrl.acc_en = 1'b1;
                        if (k_reg == len - CW'(1)) begin
                            sub_next = SUB_END;
                        end else begin
                            k_next   = k_reg + CW'(1);
                            sub_next = SUB_ADDR;
                        end
                    end
                    SUB_END: begin
                        mac_ctrl.acc_clr = 1'b1;
                        k_next   = '0;
                        sub_next = SUB_ADDR;
                        unique case (phase_reg)
                            PH_U1: begin
                                d0_next    = mac_res;
                                phase_next = PH_U2;
                            end
                            PH_U2: begin
                                b_we    = 1'b1;
                                b_waddr = BAW'(B_U + int'(i_reg));
                                b_wdata = diff;
                                if (i_reg == np_reg - CW'(1)) begin
                                    i_next     = '0;
                                    phase_next = PH_W1;
                                end else begin
                                    i_next     = i_reg + CW'(1);
                                    phase_next = PH_U1;
                                end
                            end
                            PH_W1: begin
                                d0_next    = mac_res;
                                phase_next = PH_W2;
                            end
                            PH_W2: begin
                                b_we    = 1'b1;
                                b_wdata = sum;
                                if (t_reg == '0) begin
                                    b_waddr = BAW'(B_RI + int'(i_reg));
                                end else begin
                                    b_waddr = BAW'(B_R + (int'(t_reg) - 1) * S + int'(i_reg));
                                end
                                if (i_last) begin
                                    i_next = '0;
                                    if (t_reg == '0) begin
                                        phase_next = PH_A0;
                                    end else begin
                                        t_next     = t_reg - TW'(1);
                                        phase_next = PH_U1;
                                    end
                                end else begin
                                    i_next     = i_reg + CW'(1);
                                    phase_next = PH_W1;
                                end
                            end
                            PH_A0: begin
                                d0_next    = mac_res;
                                phase_next = PH_AM;
                            end
                            PH_AM: begin
                                b_we    = 1'b1;
                                b_waddr = BAW'(B_AL + int'(i_reg));
                                b_wdata = sum;
                                if (i_last) begin
                                    i_next = '0;
                                    t_next = '0;
                                    if (n_reg == TCW'(1)) begin
                                        state_next = ST_DONE;
                                    end else begin
                                        phase_next = PH_RQ;
                                    end
                                end else begin
                                    i_next     = i_reg + CW'(1);
                                    phase_next = PH_A0;
                                end
                            end
                            PH_RQ: begin
                                b_we    = 1'b1;
                                b_waddr = BAW'(B_RQ + int'(i_reg) * N + int'(j_reg));
                                b_wdata = mac_res;
                                j_last  = (j_reg == nr_reg - CW'(1));
                                if (j_last) begin
                                    j_next = '0;
                                    if (i_last) begin
                                        i_next     = '0;
                                        phase_next = PH_RQR;
                                    end else begin
                                        i_next = i_reg + CW'(1);
                                    end
                                end else begin
                                    j_next = j_reg + CW'(1);
                                end
                            end
                            PH_RQR: begin
                                b_we    = 1'b1;
                                b_waddr = BAW'(B_RQR + int'(i_reg) * S + int'(j_reg));
                                b_wdata = mac_res;
                                j_last  = (j_reg == nm_reg - CW'(1));
                                if (j_last) begin
                                    j_next = '0;
                                    if (i_last) begin
                                        i_next     = '0;
                                        phase_next = PH_F1;
                                    end else begin
                                        i_next = i_reg + CW'(1);
                                    end
                                end else begin
                                    j_next = j_reg + CW'(1);
                                end
                            end
                            PH_F1: begin
                                d0_next    = mac_res;
                                phase_next = PH_F2;
                            end
                            PH_F2: begin
                                b_we    = 1'b1;
                                b_waddr = BAW'(B_AL + (int'(t_reg) + 1) * S + int'(i_reg));
                                b_wdata = sum;
                                if (i_last) begin
                                    i_next = '0;
                                    t_next = t_reg + TW'(1);
                                    if (int'(t_reg) + 2 < int'(n_reg)) begin
                                        phase_next = PH_RQ;
                                    end else begin
                                        state_next = ST_DONE;
                                    end
                                end else begin
                                    i_next     = i_reg + CW'(1);
                                    phase_next = PH_F1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            ST_DONE: begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_DONE;
                out_time_next  = '0;
                out_state_next = '0;
                out_val_next   = '0;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= PH_U1;
            sub_reg       <= SUB_ADDR;
            clr_reg       <= '0;
            run_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            sub_reg       <= sub_next;
            clr_reg       <= clr_next;
            run_pend_reg  <= run_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // counters and payload
    always_ff @(posedge aclk) begin
        t_reg         <= t_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        n_reg         <= n_next;
        np_reg        <= np_next;
        nm_reg        <= nm_next;
        nr_reg        <= nr_next;
        d0_reg        <= d0_next;
        rd_ok_reg     <= rd_ok_next;
        rd_time_reg   <= rd_time_next;
        rd_row_reg    <= rd_row_next;
        out_kind_reg  <= out_kind_next;
        out_time_reg  <= out_time_next;
        out_state_reg <= out_state_next;
        out_val_reg   <= out_val_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_val_reg.im, out_val_reg.re, out_state_reg, out_time_reg};

`ifndef SYNTHESIS
    // no item is taken while a result waits
    a_no_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("item accepted with a result pending");

    // work memory is never written while idle
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !b_we)
        else $error("work memory written while idle");

    // a state element result follows a read
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid) && m_tuser) |-> ($past(state_reg) == ST_READ))
        else $error("state result without a read");
`endif

endmodule

/* bench/kfss_checker.sv */
`timescale 1ns / 100ps

module kfss_checker
    import kfss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // time_index, row, col, value_re, value_im
    input  logic [79:0] s_tdata,
    // func, array_sel
    input  logic [5:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // out_time, out_state, state_re, state_im
    input  logic [79:0] m_tdata,
    // kind
    input  logic        m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_wdata,
    output int          failures,
    output int          pending,
    output int          checked
);

    localparam int NT = 64;
    localparam int NO = 4;
    localparam int NS = 8;
    localparam int NN = 4;
    localparam int FB = 16;

    typedef struct {
        longint re;
        longint im;
    } acc_t;

    typedef struct {
        logic              kind;
        logic [5:0]        tidx;
        logic [2:0]        sidx;
        logic signed [31:0] re;
        logic signed [31:0] im;
    } state_item_t;

    // model copies of the stores
    cval_t resid [NT*NO];
    cval_t gain  [NT*NS*NO];
    cval_t finv  [NT*NO*NO];
    cval_t zmat  [NT*NO*NS];
    cval_t tmat  [NT*NS*NS];
    cval_t rmat  [NT*NS*NN];
    cval_t qmat  [NT*NN*NN];
    cval_t pmean [NS];
    cval_t pcov  [NS*NS];
    cval_t rvec  [NT*NS];
    cval_t rinit [NS];
    cval_t alpha [NT*NS];

    logic [6:0] reg_times;
    logic [2:0] reg_obs;
    logic [3:0] reg_state;
    logic [2:0] reg_noise;
    logic [3:0] reg_vary;

    state_item_t expected_states[$];

    function automatic int lim(int v, int hi);
        if (v < 1) begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    // truncating complex product added to a wide accumulator
    function automatic acc_t mac(acc_t a, cval_t x, cval_t y);
        acc_t r;
        r.re = a.re + ((longint'(x.re) * longint'(y.re)) >>> FB)
                    - ((longint'(x.im) * longint'(y.im)) >>> FB);
        r.im = a.im + ((longint'(x.re) * longint'(y.im)) >>> FB)
                    + ((longint'(x.im) * longint'(y.re)) >>> FB);
        return r;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic cval_t settle(acc_t a);
        cval_t r;
        r.re = clip32(a.re);
        r.im = clip32(a.im);
        return r;
    endfunction

    function automatic cval_t csum(cval_t a, cval_t b, bit sub);
        cval_t r;
        r.re = clip32(sub ? longint'(a.re) - longint'(b.re) : longint'(a.re) + longint'(b.re));
        r.im = clip32(sub ? longint'(a.im) - longint'(b.im) : longint'(a.im) + longint'(b.im));
        return r;
    endfunction

    // backward r recursion, then forward smoothed state recursion
    task automatic smooth_states();
        int n, np, nm, nr, t, tt, i, j, k, tz, tT, tR, tQ;
        cval_t u[NO];
        cval_t w[NS];
        cval_t rq[NS*NN];
        cval_t rqr[NS*NS];
        acc_t a, b;
        n  = lim(int'(reg_times), NT);
        np = lim(int'(reg_obs), NO);
        nm = lim(int'(reg_state), NS);
        nr = lim(int'(reg_noise), NN);
        for (i = 0; i < NT*NS; i++) begin
            rvec[i]  = '0;
            alpha[i] = '0;
        end
        for (i = 0; i < NS; i++) begin
            rinit[i] = '0;
        end
        // backward pass
        for (tt = n; tt > 0; tt--) begin
            t  = tt - 1;
            tz = reg_vary[3] ? t : 0;
            tT = reg_vary[0] ? t : 0;
            for (i = 0; i < np; i++) begin
                a = '{0, 0};
                b = '{0, 0};
                for (k = 0; k < np; k++) begin
                    a = mac(a, finv[(t*NO+i)*NO+k], resid[t*NO+k]);
                end
                for (k = 0; k < nm; k++) begin
                    b = mac(b, gain[(t*NS+k)*NO+i], rvec[t*NS+k]);
                end
                u[i] = csum(settle(a), settle(b), 1'b1);
            end
            for (i = 0; i < nm; i++) begin
                a = '{0, 0};
                b = '{0, 0};
                for (k = 0; k < np; k++) begin
                    a = mac(a, zmat[(tz*NO+k)*NS+i], u[k]);
                end
                for (k = 0; k < nm; k++) begin
                    b = mac(b, tmat[(tT*NS+k)*NS+i], rvec[t*NS+k]);
                end
                w[i] = csum(settle(a), settle(b), 1'b0);
            end
            for (i = 0; i < nm; i++) begin
                if (t > 0) begin
                    rvec[(t-1)*NS+i] = w[i];
                end else begin
                    rinit[i] = w[i];
                end
            end
        end
        // state at time zero from the prior
        for (i = 0; i < nm; i++) begin
            a = '{0, 0};
            for (k = 0; k < nm; k++) begin
                a = mac(a, pcov[i*NS+k], rinit[k]);
            end
            alpha[i] = csum(settle(a), pmean[i], 1'b0);
        end
        // forward pass
        for (t = 0; t + 1 < n; t++) begin
            tT = reg_vary[0] ? t : 0;
            tR = reg_vary[1] ? t : 0;
            tQ = reg_vary[2] ? t : 0;
            for (i = 0; i < nm; i++) begin
                for (j = 0; j < nr; j++) begin
                    a = '{0, 0};
                    for (k = 0; k < nr; k++) begin
                        a = mac(a, rmat[(tR*NS+i)*NN+k], qmat[(tQ*NN+k)*NN+j]);
                    end
                    rq[i*NN+j] = settle(a);
                end
            end
            for (i = 0; i < nm; i++) begin
                for (j = 0; j < nm; j++) begin
                    a = '{0, 0};
                    for (k = 0; k < nr; k++) begin
                        a = mac(a, rq[i*NN+k], rmat[(tR*NS+j)*NN+k]);
                    end
                    rqr[i*NS+j] = settle(a);
                end
            end
            for (i = 0; i < nm; i++) begin
                a = '{0, 0};
                b = '{0, 0};
                for (k = 0; k < nm; k++) begin
                    a = mac(a, tmat[(tT*NS+i)*NS+k], alpha[t*NS+k]);
                    b = mac(b, rqr[i*NS+k], rvec[t*NS+k]);
                end
                alpha[(t+1)*NS+i] = csum(settle(a), settle(b), 1'b0);
            end
        end
    endtask

    // store one loaded element, dropping those out of range
    task automatic store_element(logic [3:0] sel, int t, int r, int c, cval_t v);
        case (sel)
            SEL_V:    if (r < NO) resid[t*NO+r] = v;
            SEL_K:    if (c < NO) gain[(t*NS+r)*NO+c] = v;
            SEL_FINV: if (r < NO && c < NO) finv[(t*NO+r)*NO+c] = v;
            SEL_Z:    if (r < NO) zmat[(t*NO+r)*NS+c] = v;
            SEL_T:    tmat[(t*NS+r)*NS+c] = v;
            SEL_R:    if (c < NN) rmat[(t*NS+r)*NN+c] = v;
            SEL_Q:    if (r < NN && c < NN) qmat[(t*NN+r)*NN+c] = v;
            SEL_PM:   pmean[r] = v;
            SEL_PC:   pcov[r*NS+c] = v;
            default: ;
        endcase
    endtask

    // follow config writes, accepted items and results
    always @(posedge aclk) begin
        state_item_t e;
        state_item_t got;
        cval_t v;
        if (!aresetn) begin
            reg_times = 7'd1;
            reg_obs   = 3'd1;
            reg_state = 4'd1;
            reg_noise = 3'd1;
            reg_vary  = 4'd0;
            for (int i = 0; i < NT*NS; i++) begin
                alpha[i] = '0;
            end
            expected_states.delete();
            failures <= 0;
            checked  <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_NUM_TIMES: reg_times = cfg_wdata;
                    CFG_OBS_DIM:   reg_obs   = cfg_wdata[2:0];
                    CFG_STATE_DIM: reg_state = cfg_wdata[3:0];
                    CFG_NOISE_DIM: reg_noise = cfg_wdata[2:0];
                    CFG_VARYING:   reg_vary  = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                v.re = s_tdata[43:12];
                v.im = s_tdata[75:44];
                case (s_tuser[1:0])
                    FUNC_LOAD: store_element(s_tuser[5:2], int'(s_tdata[5:0]),
                                             int'(s_tdata[8:6]), int'(s_tdata[11:9]), v);
                    FUNC_START: begin
                        smooth_states();
                        expected_states.push_back('{KIND_DONE, 6'd0, 3'd0, 32'sd0, 32'sd0});
                    end
                    FUNC_READ: begin
                        v = alpha[int'(s_tdata[5:0])*NS + int'(s_tdata[8:6])];
                        expected_states.push_back('{KIND_STATE, s_tdata[5:0], s_tdata[8:6],
                                                    v.re, v.im});
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[5:0], m_tdata[8:6], m_tdata[40:9], m_tdata[72:41]};
                checked <= checked + 1;
                if (expected_states.size() == 0) begin
                    $error("result with nothing expected: kind %0d time %0d", got.kind, got.tidx);
                    failures <= failures + 1;
                end else begin
                    e = expected_states.pop_front();
                    if (got.kind !== e.kind || got.tidx !== e.tidx || got.sidx !== e.sidx ||
                        got.re !== e.re || got.im !== e.im) begin
                        failures <= failures + 1;
                        if (got.kind !== e.kind)
                            $error("kind exp %0d got %0d", e.kind, got.kind);
                        if (got.tidx !== e.tidx)
                            $error("out_time exp %0d got %0d", e.tidx, got.tidx);
                        if (got.sidx !== e.sidx)
                            $error("out_state exp %0d got %0d", e.sidx, got.sidx);
                        if (got.re !== e.re)
                            $error("state_re exp %0d got %0d", e.re, got.re);
                        if (got.im !== e.im)
                            $error("state_im exp %0d got %0d", e.im, got.im);
                    end
                end
            end
        end
        pending <= expected_states.size();
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import kfss_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [5:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [6:0]  cfg_wdata;

    int failures;
    int pending;
    int checked;
    int send_idle;
    int recv_idle;
    int hold_req;
    int hold_done;
    int hold_left;
    int items_sent;
    int runs_done;

    // which store entries have been loaded at least once
    bit loaded [0:8][0:63][0:7][0:7];

    kalman_fast_state_smoother i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    kfss_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .failures  (failures),
        .pending   (pending),
        .checked   (checked)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls plus requested long hold-offs
    initial begin
        hold_done = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else if (hold_req != hold_done) begin
                hold_done = hold_done + 1;
                hold_left = 400;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    function automatic int lim(int v, int hi);
        if (v < 1) begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    // mostly small Q16.16 values, sometimes any 32-bit pattern
    function automatic int rand_value();
        if ($urandom_range(0, 9) < 7) begin
            return int'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
        end
        return int'($urandom);
    endfunction

    task automatic send(logic [1:0] f, logic [3:0] sel, logic [5:0] t, logic [2:0] r,
                        logic [2:0] c, int re, int im);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {sel, f};
        s_tdata  <= {4'b0, im, re, c, r, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // load an element and remember which entry it defines
    task automatic load(logic [3:0] sel, logic [5:0] t, logic [2:0] r, logic [2:0] c,
                        int re, int im);
        bit ok;
        send(FUNC_LOAD, sel, t, r, c, re, im);
        case (sel)
            SEL_V:    ok = (r < 4);
            SEL_K:    ok = (c < 4);
            SEL_FINV: ok = (r < 4 && c < 4);
            SEL_Z:    ok = (r < 4);
            SEL_T:    ok = 1'b1;
            SEL_R:    ok = (c < 4);
            SEL_Q:    ok = (r < 4 && c < 4);
            SEL_PM:   ok = 1'b1;
            SEL_PC:   ok = 1'b1;
            default:  ok = 1'b0;
        endcase
        if (ok) begin
            loaded[sel][(sel >= SEL_PM) ? 6'd0 : t][r][(sel == SEL_V || sel == SEL_PM) ? 3'd0 : c] = 1'b1;
        end
    endtask

    task automatic need(logic [3:0] sel, int t, int r, int c);
        if (!loaded[sel][t][r][c]) begin
            load(sel, t, r, c, rand_value(), rand_value());
        end
    endtask

    // load every entry a run with these settings reads and that is still unset
    task automatic fill_for_run(int nt, int od, int sd, int nd, int vf);
        int n, np, nm, nr, t, r, c, vt;
        n  = lim(nt, 64);
        np = lim(od, 4);
        nm = lim(sd, 8);
        nr = lim(nd, 4);
        for (t = 0; t < n; t++) begin
            for (r = 0; r < np; r++) begin
                need(SEL_V, t, r, 0);
                for (c = 0; c < np; c++) need(SEL_FINV, t, r, c);
            end
            for (r = 0; r < nm; r++) begin
                for (c = 0; c < np; c++) need(SEL_K, t, r, c);
            end
            vt = vf[3] ? t : 0;
            for (r = 0; r < np; r++) begin
                for (c = 0; c < nm; c++) need(SEL_Z, vt, r, c);
            end
            vt = vf[0] ? t : 0;
            for (r = 0; r < nm; r++) begin
                for (c = 0; c < nm; c++) need(SEL_T, vt, r, c);
            end
            vt = vf[1] ? t : 0;
            for (r = 0; r < nm; r++) begin
                for (c = 0; c < nr; c++) need(SEL_R, vt, r, c);
            end
            vt = vf[2] ? t : 0;
            for (r = 0; r < nr; r++) begin
                for (c = 0; c < nr; c++) need(SEL_Q, vt, r, c);
            end
        end
        for (r = 0; r < nm; r++) begin
            need(SEL_PM, 0, r, 0);
            for (c = 0; c < nm; c++) need(SEL_PC, 0, r, c);
        end
    endtask

    // let every result drain and the block go quiet
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_config(int nt, int od, int sd, int nd, int vf);
        int vals[5];
        vals = '{nt, od, sd, nd, vf};
        wait_idle();
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= 7'(vals[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic read_state(logic [5:0] t, logic [2:0] r);
        send(FUNC_READ, 4'($urandom), t, r, 3'($urandom), int'($urandom), int'($urandom));
    endtask

    // stimulus
    initial begin
        int nt, od, sd, nd, vf, n, nm, ph;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        send_idle = 11;
        recv_idle = 46;
        hold_req  = 0;
        items_sent = 0;
        runs_done = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // clearing pass after reset
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);

        // directed: extremes, every array, ignored loads and odd funcs
        set_config(1, 1, 1, 1, 0);
        load(SEL_V, 0, 0, 7, 32'sh7FFF_FFFF, 32'sh8000_0000);
        load(SEL_FINV, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        load(SEL_K, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        load(SEL_Z, 0, 0, 0, 32'sh8000_0000, 32'sh8000_0000);
        load(SEL_T, 0, 0, 0, 32'sh0001_0000, 0);
        load(SEL_R, 0, 0, 0, 0, 32'sh0001_0000);
        load(SEL_Q, 0, 0, 0, 32'sh7FFF_FFFF, -1);
        load(SEL_PM, 63, 0, 5, -1, 32'sh7FFF_FFFF);
        load(SEL_PC, 63, 0, 0, 32'sh0002_0000, 32'sh8000_0000);
        load(4'd9, 0, 0, 0, 1, 1);
        load(4'd15, 63, 7, 7, -1, -1);
        load(SEL_V, 0, 5, 0, 5, 5);
        load(SEL_K, 0, 0, 6, 7, 7);
        send(2'd3, SEL_T, 0, 0, 0, 9, 9);
        send(FUNC_START, 4'd0, 0, 0, 0, 0, 0);
        runs_done++;
        read_state(0, 0);
        read_state(63, 7);
        read_state(0, 4);
        // out-of-range registers clamp to one
        set_config(0, 0, 0, 0, 0);
        send(FUNC_START, 4'd15, 63, 7, 7, -1, -1);
        runs_done++;
        read_state(0, 0);
        read_state(1, 0);

        // random phases of loads, a run and reads
        ph = 0;
        while (items_sent < 1100) begin
            if (items_sent < 370) begin
                send_idle = 11;
                recv_idle = 46;
            end else if (items_sent < 740) begin
                send_idle = 46;
                recv_idle = 11;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (ph == 2) begin
                // full time length, clamped from above
                nt = 127; od = 1; sd = 1; nd = 1; vf = 0;
            end else if (ph == 4) begin
                // every dimension clamped from above, all matrices per time
                nt = 2; od = 7; sd = 15; nd = 7; vf = 15;
            end else begin
                nt = $urandom_range(1, 4);
                od = $urandom_range(0, 7);
                sd = $urandom_range(0, 15);
                nd = $urandom_range(0, 7);
                vf = $urandom_range(0, 15);
            end
            n  = lim(nt, 64);
            nm = lim(sd, 8);
            set_config(nt, od, sd, nd, vf);
            fill_for_run(nt, od, sd, nd, vf);
            // loads to valid arrays and times, random rows, columns and content
            repeat ($urandom_range(15, 40)) begin
                load(4'($urandom_range(0, 8)), 6'($urandom_range(0, n - 1)), 3'($urandom),
                     3'($urandom), rand_value(), rand_value());
            end
            // noise: any array select, any position, unused func
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 1)) begin
                    load(4'($urandom), 6'($urandom), 3'($urandom), 3'($urandom),
                         int'($urandom), int'($urandom));
                end else begin
                    send(2'd3, 4'($urandom), 6'($urandom), 3'($urandom), 3'($urandom),
                         int'($urandom), int'($urandom));
                end
            end
            send(FUNC_START, 4'($urandom), 6'($urandom), 3'($urandom), 3'($urandom),
                 int'($urandom), int'($urandom));
            runs_done++;
            // first read goes in once the run is over
            read_state(6'($urandom_range(0, n - 1)), 3'($urandom_range(0, nm - 1)));
            // in some phases a long receiver hold-off while reads keep coming
            if (ph == 1 || ph == 3) begin
                hold_req++;
            end
            repeat ($urandom_range(15, 35)) begin
                if ($urandom_range(0, 4) != 0) begin
                    read_state(6'($urandom_range(0, n - 1)), 3'($urandom_range(0, nm - 1)));
                end else begin
                    read_state(6'($urandom), 3'($urandom));
                end
            end
            ph++;
        end

        // drain and report
        wait_idle();
        repeat (50) @(posedge aclk);
        $display("covered %0d items, %0d smoothing runs over %0d settings, %0d results checked",
                 items_sent, runs_done, ph + 2, checked);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
